>>> sv/orss_pkg.sv
`timescale 1ns / 1ps

package orss_pkg;

   localparam int NUM_COLUMNS_DEF  = 64;
   localparam int COUNT_BITS_DEF   = 16;

   localparam int ROW_BITS         = 64;
   localparam int COUNT_FIELD_BITS = 16;
   localparam int SCORE_BITS       = 32;
   localparam int MIN_CHILD_BITS   = 16;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 64;

   localparam logic [SCORE_BITS-1:0] SCORE_MAX = {SCORE_BITS{1'b1}};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RULE_MASK        = 2'd0,
      CSR_MIN_CHILD_SIZE   = 2'd1,
      CSR_REQUIRE_OPPOSITE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic fp_big;
      logic fn_small;
      logic sizes_ok;
      logic opposite;
      logic qualifies;
   } split_flags_type;

endpackage

>>> sv/or_rule_split_scorer_top.sv
`timescale 1ns / 1ps
// Throughput: one row per cycle while rsp_ready does not hold back the result path; rows
// that are not the last of a data set produce no item. The result item for a last row
// passes through the snapshot of the final counts, four parallel products, then sum,
// bound select and score saturation into the result register.
// Reset is synchronous and active high; it clears the counters, the configuration
// registers and all valid flags.
module or_rule_split_scorer_top #(
   parameter int NUM_COLUMNS = orss_pkg::NUM_COLUMNS_DEF,
   parameter int COUNT_BITS  = orss_pkg::COUNT_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_label,
   input  logic [orss_pkg::ROW_BITS-1:0]           req_row_bits,
   input  logic                                    req_last_row,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [orss_pkg::COUNT_FIELD_BITS-1:0]   rsp_false_pos,
   output logic [orss_pkg::COUNT_FIELD_BITS-1:0]   rsp_false_neg,
   output logic [orss_pkg::COUNT_FIELD_BITS-1:0]   rsp_pred_neg_count,
   output logic [orss_pkg::COUNT_FIELD_BITS-1:0]   rsp_pred_pos_count,
   output logic [orss_pkg::SCORE_BITS-1:0]         rsp_objective,
   output logic [orss_pkg::SCORE_BITS-1:0]         rsp_bound,
   output logic                                    rsp_sizes_ok,
   output logic                                    rsp_opposite_majority,
   output logic                                    rsp_qualifies,
   input  logic                                    csr_we,
   input  logic [orss_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [orss_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int MUL_W = 2 * COUNT_BITS;
   localparam int OBJ_W = MUL_W + 1;
   localparam int EXT_W = (OBJ_W > orss_pkg::SCORE_BITS) ? OBJ_W : orss_pkg::SCORE_BITS;
   localparam int CMP_W = (COUNT_BITS > orss_pkg::MIN_CHILD_BITS) ?
                          COUNT_BITS : orss_pkg::MIN_CHILD_BITS;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [MUL_W-1:0]      prod_type;

   function automatic count_type sat_inc(input count_type c, input logic en);
      count_type r;
      r = c;
      if (en && (c != CNT_MAX)) begin
         r = c + 1'b1;
      end
      return r;
   endfunction

   // Configuration registers.
   logic [NUM_COLUMNS-1:0]                rule_mask_ff;
   logic [orss_pkg::MIN_CHILD_BITS-1:0]   min_child_ff;
   logic                                  require_opp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_mask_ff   <= '0;
         min_child_ff   <= '0;
         require_opp_ff <= 1'b0;
      end else if (csr_we) begin
         if (csr_index == orss_pkg::CSR_RULE_MASK) begin
            rule_mask_ff <= csr_wdata[NUM_COLUMNS-1:0];
         end else if (csr_index == orss_pkg::CSR_MIN_CHILD_SIZE) begin
            min_child_ff <= csr_wdata[orss_pkg::MIN_CHILD_BITS-1:0];
         end else if (csr_index == orss_pkg::CSR_REQUIRE_OPPOSITE) begin
            require_opp_ff <= csr_wdata[0];
         end
      end
   end

   // Pipeline flow control.
   logic p1_valid_ff;
   logic p2_valid_ff;
   logic rsp_valid_ff;
   logic out_move;
   logic p2_move;
   logic p1_move;
   logic accept;

   assign out_move  = !rsp_valid_ff || rsp_ready;
   assign p2_move   = !p2_valid_ff || out_move;
   assign p1_move   = !p1_valid_ff || p2_move;
   assign req_ready = p1_move;
   assign accept    = req_valid && req_ready;

   // Stage 0: running counters.
   count_type neg_rows_ff, pos_rows_ff, fp_count_ff, fn_count_ff, pneg_ff, ppos_ff;
   count_type neg_rows_in, pos_rows_in, fp_count_in, fn_count_in, pneg_in, ppos_in;
   logic      hit;

   assign hit = |(req_row_bits[NUM_COLUMNS-1:0] & rule_mask_ff);

   always_comb begin
      neg_rows_in = sat_inc(neg_rows_ff, !req_label);
      pos_rows_in = sat_inc(pos_rows_ff, req_label);
      fp_count_in = sat_inc(fp_count_ff, !req_label && hit);
      fn_count_in = sat_inc(fn_count_ff, req_label && !hit);
      pneg_in     = sat_inc(pneg_ff, !hit);
      ppos_in     = sat_inc(ppos_ff, hit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_rows_ff <= '0;
         pos_rows_ff <= '0;
         fp_count_ff <= '0;
         fn_count_ff <= '0;
         pneg_ff     <= '0;
         ppos_ff     <= '0;
      end else if (accept) begin
         if (req_last_row) begin
            neg_rows_ff <= '0;
            pos_rows_ff <= '0;
            fp_count_ff <= '0;
            fn_count_ff <= '0;
            pneg_ff     <= '0;
            ppos_ff     <= '0;
         end else begin
            neg_rows_ff <= neg_rows_in;
            pos_rows_ff <= pos_rows_in;
            fp_count_ff <= fp_count_in;
            fn_count_ff <= fn_count_in;
            pneg_ff     <= pneg_in;
            ppos_ff     <= ppos_in;
         end
      end
   end

   // Stage 1: snapshot of the final counts of a data set.
   count_type n0_1_ff, n1_1_ff, fp_1_ff, fn_1_ff, pneg_1_ff, ppos_1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (p1_move) begin
         p1_valid_ff <= accept && req_last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (p1_move && accept && req_last_row) begin
         n0_1_ff   <= neg_rows_in;
         n1_1_ff   <= pos_rows_in;
         fp_1_ff   <= fp_count_in;
         fn_1_ff   <= fn_count_in;
         pneg_1_ff <= pneg_in;
         ppos_1_ff <= ppos_in;
      end
   end

   // Stage 1 logic: products and flags.
   count_type                  tp_1;
   count_type                  tn_1;
   prod_type                   fp_tp_in, fn_tn_in, n0_tp_in, n1_fp_in;
   orss_pkg::split_flags_type  flags_in;

   always_comb begin
      tp_1     = n1_1_ff - fn_1_ff;
      tn_1     = n0_1_ff - fp_1_ff;
      fp_tp_in = MUL_W'(fp_1_ff) * MUL_W'(tp_1);
      fn_tn_in = MUL_W'(fn_1_ff) * MUL_W'(tn_1);
      n0_tp_in = MUL_W'(n0_1_ff) * MUL_W'(tp_1);
      n1_fp_in = MUL_W'(n1_1_ff) * MUL_W'(fp_1_ff);
      flags_in.fp_big    = {fp_1_ff, 1'b0} >= {1'b0, n0_1_ff};
      flags_in.fn_small  = {fn_1_ff, 1'b0} <= {1'b0, n1_1_ff};
      flags_in.sizes_ok  = (CMP_W'(pneg_1_ff) >= CMP_W'(min_child_ff)) &&
                           (CMP_W'(ppos_1_ff) >= CMP_W'(min_child_ff));
      flags_in.opposite  = ((tp_1 > fp_1_ff) && (fn_1_ff < tn_1)) ||
                           ((tp_1 < fp_1_ff) && (fn_1_ff > tn_1));
      flags_in.qualifies = flags_in.sizes_ok && (flags_in.opposite || !require_opp_ff);
   end

   // Stage 2 registers.
   prod_type                                 fp_tp_ff, fn_tn_ff, n0_tp_ff, n1_fp_ff;
   orss_pkg::split_flags_type                flags_ff;
   logic [orss_pkg::COUNT_FIELD_BITS-1:0]    fp_2_ff, fn_2_ff, pneg_2_ff, ppos_2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (p2_move) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p2_move && p1_valid_ff) begin
         fp_tp_ff  <= fp_tp_in;
         fn_tn_ff  <= fn_tn_in;
         n0_tp_ff  <= n0_tp_in;
         n1_fp_ff  <= n1_fp_in;
         flags_ff  <= flags_in;
         fp_2_ff   <= orss_pkg::COUNT_FIELD_BITS'(fp_1_ff);
         fn_2_ff   <= orss_pkg::COUNT_FIELD_BITS'(fn_1_ff);
         pneg_2_ff <= orss_pkg::COUNT_FIELD_BITS'(pneg_1_ff);
         ppos_2_ff <= orss_pkg::COUNT_FIELD_BITS'(ppos_1_ff);
      end
   end

   // Stage 2 logic: objective, bound and score saturation.
   logic [OBJ_W-1:0]                  obj_2;
   logic [OBJ_W-1:0]                  bnd_2;
   logic [EXT_W-1:0]                  obj_ext;
   logic [EXT_W-1:0]                  bnd_ext;
   logic [orss_pkg::SCORE_BITS-1:0]   objective_in;
   logic [orss_pkg::SCORE_BITS-1:0]   bound_in;

   always_comb begin
      obj_2 = OBJ_W'(fp_tp_ff) + OBJ_W'(fn_tn_ff);
      if (flags_ff.fp_big) begin
         bnd_2 = flags_ff.fn_small ? obj_2 : OBJ_W'(n0_tp_ff);
      end else begin
         bnd_2 = flags_ff.fn_small ? OBJ_W'(n1_fp_ff) : '0;
      end
      obj_ext      = EXT_W'(obj_2);
      bnd_ext      = EXT_W'(bnd_2);
      objective_in = (obj_ext > EXT_W'(orss_pkg::SCORE_MAX)) ?
                     orss_pkg::SCORE_MAX : orss_pkg::SCORE_BITS'(obj_ext);
      bound_in     = (bnd_ext > EXT_W'(orss_pkg::SCORE_MAX)) ?
                     orss_pkg::SCORE_MAX : orss_pkg::SCORE_BITS'(bnd_ext);
   end

   // Result register.
   logic [orss_pkg::COUNT_FIELD_BITS-1:0]   out_fp_ff, out_fn_ff, out_pneg_ff, out_ppos_ff;
   logic [orss_pkg::SCORE_BITS-1:0]         out_objective_ff;
   logic [orss_pkg::SCORE_BITS-1:0]         out_bound_ff;
   orss_pkg::split_flags_type               out_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_move) begin
         rsp_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_move && p2_valid_ff) begin
         out_fp_ff        <= fp_2_ff;
         out_fn_ff        <= fn_2_ff;
         out_pneg_ff      <= pneg_2_ff;
         out_ppos_ff      <= ppos_2_ff;
         out_objective_ff <= objective_in;
         out_bound_ff     <= bound_in;
         out_flags_ff     <= flags_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_false_pos         = out_fp_ff;
   assign rsp_false_neg         = out_fn_ff;
   assign rsp_pred_neg_count    = out_pneg_ff;
   assign rsp_pred_pos_count    = out_ppos_ff;
   assign rsp_objective         = out_objective_ff;
   assign rsp_bound             = out_bound_ff;
   assign rsp_sizes_ok          = out_flags_ff.sizes_ok;
   assign rsp_opposite_majority = out_flags_ff.opposite;
   assign rsp_qualifies         = out_flags_ff.qualifies;

   // Error counts never exceed the class counts they are drawn from.
   a_counts_consistent : assert property (@(posedge clock) disable iff (reset)
      (fp_count_ff <= neg_rows_ff) && (fn_count_ff <= pos_rows_ff))
      else $error("error count exceeds class count");

   // The last row of a data set leaves the counters cleared.
   a_clear_after_last : assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_row) |=> (neg_rows_ff == '0) && (pos_rows_ff == '0) &&
                                   (pneg_ff == '0) && (ppos_ff == '0))
      else $error("counters not cleared after last row");

   // No result item is offered right after reset.
   a_no_result_after_reset : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int CW          = orss_pkg::COUNT_BITS_DEF;
   localparam int LATENCY     = 2;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ROWS = 590;
   localparam logic [orss_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      bit [orss_pkg::COUNT_FIELD_BITS-1:0] false_pos;
      bit [orss_pkg::COUNT_FIELD_BITS-1:0] false_neg;
      bit [orss_pkg::COUNT_FIELD_BITS-1:0] pred_neg;
      bit [orss_pkg::COUNT_FIELD_BITS-1:0] pred_pos;
      bit [orss_pkg::SCORE_BITS-1:0]       objective;
      bit [orss_pkg::SCORE_BITS-1:0]       bound;
      bit                                  sizes_ok;
      bit                                  opposite;
      bit                                  qualifies;
   } split_score_type;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_ready;
   logic                                   req_label = 1'b0;
   logic [orss_pkg::ROW_BITS-1:0]          req_row_bits = '0;
   logic                                   req_last_row = 1'b0;
   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   logic [orss_pkg::COUNT_FIELD_BITS-1:0]  rsp_false_pos;
   logic [orss_pkg::COUNT_FIELD_BITS-1:0]  rsp_false_neg;
   logic [orss_pkg::COUNT_FIELD_BITS-1:0]  rsp_pred_neg_count;
   logic [orss_pkg::COUNT_FIELD_BITS-1:0]  rsp_pred_pos_count;
   logic [orss_pkg::SCORE_BITS-1:0]        rsp_objective;
   logic [orss_pkg::SCORE_BITS-1:0]        rsp_bound;
   logic                                   rsp_sizes_ok;
   logic                                   rsp_opposite_majority;
   logic                                   rsp_qualifies;
   logic                                   csr_we = 1'b0;
   logic [orss_pkg::CSR_INDEX_BITS-1:0]    csr_index = '0;
   logic [orss_pkg::CSR_DATA_BITS-1:0]     csr_wdata = '0;

   bit [orss_pkg::ROW_BITS-1:0]       mask_cfg;
   bit [orss_pkg::MIN_CHILD_BITS-1:0] min_child_cfg;
   bit                                opposite_cfg;

   bit [CW-1:0] neg_tally;
   bit [CW-1:0] pos_tally;
   bit [CW-1:0] fp_tally;
   bit [CW-1:0] fn_tally;
   bit [CW-1:0] pred_neg_tally;
   bit [CW-1:0] pred_pos_tally;

   split_score_type pending_scores[$];
   int              error_count;
   int              rows_sent;
   int              sets_sent;
   int              scores_checked;
   longint          cycle_count;
   bit              calm;

   or_rule_split_scorer_top dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   function automatic bit [CW-1:0] sat_up(bit [CW-1:0] c);
      return (&c) ? c : c + 1'b1;
   endfunction

   // Counts one accepted row and, on the last row of a data set, queues its score.
   function automatic void tally_row(bit label, bit [orss_pkg::ROW_BITS-1:0] row, bit last);
      bit              hit;
      longint unsigned n0, n1, fp, fn, tn, tp, obj, bnd;
      split_score_type s;
      hit = (row & mask_cfg) != '0;
      if (label) begin
         pos_tally = sat_up(pos_tally);
         if (hit) begin
            pred_pos_tally = sat_up(pred_pos_tally);
         end else begin
            fn_tally = sat_up(fn_tally);
            pred_neg_tally = sat_up(pred_neg_tally);
         end
      end else begin
         neg_tally = sat_up(neg_tally);
         if (hit) begin
            fp_tally = sat_up(fp_tally);
            pred_pos_tally = sat_up(pred_pos_tally);
         end else begin
            pred_neg_tally = sat_up(pred_neg_tally);
         end
      end
      if (!last) return;
      n0 = neg_tally;
      n1 = pos_tally;
      fp = fp_tally;
      fn = fn_tally;
      tn = n0 - fp;
      tp = n1 - fn;
      obj = fp * tp + fn * tn;
      if (2 * fp >= n0) begin
         bnd = (2 * fn <= n1) ? obj : n0 * tp;
      end else begin
         bnd = (2 * fn <= n1) ? n1 * fp : 0;
      end
      s.false_pos = fp[orss_pkg::COUNT_FIELD_BITS-1:0];
      s.false_neg = fn[orss_pkg::COUNT_FIELD_BITS-1:0];
      s.pred_neg = pred_neg_tally[orss_pkg::COUNT_FIELD_BITS-1:0];
      s.pred_pos = pred_pos_tally[orss_pkg::COUNT_FIELD_BITS-1:0];
      s.objective = (obj > orss_pkg::SCORE_MAX) ?
                    orss_pkg::SCORE_MAX : obj[orss_pkg::SCORE_BITS-1:0];
      s.bound = (bnd > orss_pkg::SCORE_MAX) ?
                orss_pkg::SCORE_MAX : bnd[orss_pkg::SCORE_BITS-1:0];
      s.sizes_ok = pred_neg_tally >= min_child_cfg && pred_pos_tally >= min_child_cfg;
      s.opposite = (tp > fp && fn < tn) || (tp < fp && fn > tn);
      s.qualifies = s.sizes_ok && (s.opposite || !opposite_cfg);
      pending_scores.push_back(s);
      neg_tally = '0;
      pos_tally = '0;
      fp_tally = '0;
      fn_tally = '0;
      pred_neg_tally = '0;
      pred_pos_tally = '0;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   function automatic bit [orss_pkg::ROW_BITS-1:0] make_row(bit hit);
      bit [orss_pkg::ROW_BITS-1:0] noise;
      int                          col;
      noise = {$urandom, $urandom};
      if (!hit || mask_cfg == '0) return noise & ~mask_cfg;
      col = $urandom_range(0, orss_pkg::ROW_BITS - 1);
      while (!mask_cfg[col]) col = $urandom_range(0, orss_pkg::ROW_BITS - 1);
      return noise | (64'b1 << col);
   endfunction

   task automatic write_csr(logic [orss_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [orss_pkg::CSR_DATA_BITS-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         orss_pkg::CSR_RULE_MASK: begin
            mask_cfg = data;
         end
         orss_pkg::CSR_MIN_CHILD_SIZE: begin
            min_child_cfg = data[orss_pkg::MIN_CHILD_BITS-1:0];
         end
         orss_pkg::CSR_REQUIRE_OPPOSITE: begin
            opposite_cfg = data[0];
         end
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic send_row(bit label, bit [orss_pkg::ROW_BITS-1:0] row, bit last);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_label <= label;
      req_row_bits <= row;
      req_last_row <= last;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      tally_row(label, row, last);
      rows_sent++;
      if (last) sets_sent++;
   endtask

   // Sends one data set with the given mix of rows in random order.
   task automatic send_set(int neg_hit, int neg_miss, int pos_hit, int pos_miss);
      int left [4];
      int total;
      int pick;
      int kind;
      left = '{neg_hit, neg_miss, pos_hit, pos_miss};
      total = neg_hit + neg_miss + pos_hit + pos_miss;
      while (total > 0) begin
         pick = $urandom_range(0, total - 1);
         kind = 0;
         while (pick >= left[kind]) begin
            pick -= left[kind];
            kind++;
         end
         left[kind]--;
         total--;
         send_row(kind >= 2, make_row(kind[0] == 1'b0), total == 0);
      end
   endtask

   task automatic test_reset_state();
      send_row(1'b1, '1, 1'b1);
      send_row(1'b0, '0, 1'b1);
   endtask

   task automatic test_column_extremes();
      wait_idle();
      write_csr(orss_pkg::CSR_RULE_MASK, '1);
      send_row(1'b1, 64'h1, 1'b0);
      send_row(1'b0, {1'b1, 63'b0}, 1'b0);
      send_row(1'b1, '0, 1'b0);
      send_row(1'b0, '1, 1'b1);
      wait_idle();
      write_csr(orss_pkg::CSR_RULE_MASK, {1'b1, 62'b0, 1'b1});
      send_row(1'b0, {1'b0, {62{1'b1}}, 1'b0}, 1'b0);
      send_row(1'b1, {1'b1, 63'b0}, 1'b1);
   endtask

   task automatic test_unused_index();
      wait_idle();
      write_csr(CSR_UNUSED, '1);
      send_row(1'b0, '1, 1'b1);
   endtask

   task automatic test_bound_regions();
      wait_idle();
      write_csr(orss_pkg::CSR_RULE_MASK, {$urandom, $urandom} | 64'h1);
      send_set(1, 0, 0, 0);
      send_set(1, 0, 1, 2);
      send_set(1, 2, 1, 0);
      send_set(0, 1, 0, 1);
   endtask

   task automatic test_child_rules();
      wait_idle();
      write_csr(orss_pkg::CSR_MIN_CHILD_SIZE, 64'd2);
      write_csr(orss_pkg::CSR_REQUIRE_OPPOSITE, 64'd1);
      send_set(0, 2, 2, 0);
      wait_idle();
      write_csr(orss_pkg::CSR_MIN_CHILD_SIZE, 64'd0);
      send_set(0, 1, 0, 1);
   endtask

   task automatic test_random_sets();
      int                          start;
      int                          phase;
      int                          nh, nm, ph, pm;
      bit [orss_pkg::ROW_BITS-1:0] mask;
      bit [63:0]                   wide;
      start = rows_sent;
      phase = 0;
      while (rows_sent - start < RANDOM_ROWS) begin
         wait_idle();
         case (phase % 5)
            0: mask = 64'b1 << $urandom_range(0, orss_pkg::ROW_BITS - 1);
            1: mask = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            2: mask = {$urandom, $urandom} | {$urandom, $urandom};
            3: mask = '1;
            default: mask = (phase % 10 == 4) ? '0 : {$urandom, $urandom};
         endcase
         write_csr(orss_pkg::CSR_RULE_MASK, mask);
         wide = {$urandom, $urandom};
         if (phase % 4 == 3) begin
            wide[orss_pkg::MIN_CHILD_BITS-1:0] = '1;
         end else begin
            wide[orss_pkg::MIN_CHILD_BITS-1:0] = $urandom_range(0, 6);
         end
         write_csr(orss_pkg::CSR_MIN_CHILD_SIZE, wide);
         write_csr(orss_pkg::CSR_REQUIRE_OPPOSITE, {$urandom, $urandom});
         repeat (6) begin
            calm = (phase % 3 == 0) || ($urandom_range(0, 4) == 0);
            nh = $urandom_range(0, 6);
            nm = $urandom_range(0, 6);
            ph = $urandom_range(0, 6);
            pm = $urandom_range(0, 6);
            if (nh + nm + ph + pm == 0) ph = 1;
            send_set(nh, nm, ph, pm);
         end
         phase++;
      end
      calm = 1'b0;
   endtask

   initial begin : score_checker
      split_score_type want;
      int              gap;
      wait (reset == 1'b0);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
         while (!rsp_valid) @(negedge clock);
         if (pending_scores.size() == 0) begin
            $display("%0t: unexpected result item, expected none, actual false_pos %0d",
                     $time, rsp_false_pos);
            error_count++;
         end else begin
            want = pending_scores.pop_front();
            check_field("false_pos", want.false_pos, rsp_false_pos);
            check_field("false_neg", want.false_neg, rsp_false_neg);
            check_field("pred_neg_count", want.pred_neg, rsp_pred_neg_count);
            check_field("pred_pos_count", want.pred_pos, rsp_pred_pos_count);
            check_field("objective", want.objective, rsp_objective);
            check_field("bound", want.bound, rsp_bound);
            check_field("sizes_ok", want.sizes_ok, rsp_sizes_ok);
            check_field("opposite_majority", want.opposite, rsp_opposite_majority);
            check_field("qualifies", want.qualifies, rsp_qualifies);
         end
         scores_checked++;
         @(posedge clock);
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_column_extremes();
      test_unused_index();
      test_bound_regions();
      test_child_rules();
      test_random_sets();
      wait_idle();
      $display("Scored %0d rows in %0d data sets and checked %0d result items.",
               rows_sent, sets_sent, scores_checked);
      $display("Masks ranged from empty to full, with every bound region and child rule.");
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
